@@ src/ms_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ms_pkg;

	localparam int DATA_W       = 32;
	localparam int CAPACITY_DEF = 64;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_START = 4'b0010,
		ST_MERGE = 4'b0100,
		ST_EMIT  = 4'b1000
	} ms_state_t;

endpackage

`default_nettype wire

@@ src/merge_sorter_core.sv @@
// channel   signals                            role
// in        in_valid, in_stall, value, last    one element per word, last closes the block
// out       out_valid, out_stall, value_res,   sorted elements, last_res on the final one,
//           last_res, overflow                 overflow when elements were dropped
//
// a block of n words is taken at one word per cycle into bank 0
// the sort runs ceil(log2 n) bottom-up merge passes, each a start state and a merge state,
// one merge compare per cycle between the two banks
// results then leave at one word per cycle, while out_stall is low, through an output register
// reset clears control state only, the banks need no clearing pass
// in_stall is high from the closing word until the final result is loaded;
// out_stall only holds the output register and the read ahead of it
`timescale 1ns / 1ps
`default_nettype none

module merge_sorter_core
	import ms_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire  signed [DATA_W-1:0]   value,
	input  wire                        last,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic signed [DATA_W-1:0]   value_res,
	output logic                       last_res,
	output logic                       overflow
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);

	ms_state_t state_q;

	logic [CNT_W-1:0] count_q;
	logic             dropped_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] w_q;
	logic [CNT_W-1:0] a_q, b_q, mid_q, hi_q, k_q;
	logic [CNT_W-1:0] nmid_q, nhi_q;
	logic             sel_q;
	logic [CNT_W-1:0] e_q;
	logic             pend_q;
	logic             pend_last_q;

	logic signed [DATA_W-1:0] bank0_q [CAPACITY];
	logic signed [DATA_W-1:0] bank1_q [CAPACITY];
	logic signed [DATA_W-1:0] rd0a_q, rd0b_q, rd1a_q, rd1b_q;

	logic                     in_acc;
	logic                     store;
	logic [CNT_W-1:0]         count_nxt;
	logic signed [DATA_W-1:0] va, vb, wdata;
	logic                     take_a;
	logic [CNT_W-1:0]         a_inc, b_inc;
	logic                     run_end, pass_end, sort_done;
	logic [CNT_W:0]           hw_sum, hw2_sum, w2, hi_start;
	logic                     rd_en;
	logic [CNT_W-1:0]         ra, rb;
	logic                     out_free, emit_issue, emit_load;
	logic                     we0, we1;
	logic [CNT_W-1:0]         wa0;
	logic signed [DATA_W-1:0] wd0;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign store    = in_acc && (count_q < CNT_W'(CAPACITY));
	assign count_nxt = store ? count_q + CNT_W'(1) : count_q;

	// merge decision on the two heads read last cycle
	assign va = sel_q ? rd1a_q : rd0a_q;
	assign vb = sel_q ? rd1b_q : rd0b_q;
	assign take_a = (a_q < mid_q) && ((b_q >= hi_q) || (va < vb));
	assign wdata  = take_a ? va : vb;
	assign a_inc  = take_a ? a_q + CNT_W'(1) : a_q;
	assign b_inc  = take_a ? b_q : b_q + CNT_W'(1);
	assign run_end  = (k_q + CNT_W'(1)) == hi_q;
	assign pass_end = (k_q + CNT_W'(1)) == n_q;

	assign w2        = {w_q, 1'b0};
	assign sort_done = w2 >= {1'b0, n_q};
	assign hi_start  = (w2 < {1'b0, n_q}) ? w2 : {1'b0, n_q};
	assign hw_sum    = {1'b0, hi_q} + {1'b0, w_q};
	assign hw2_sum   = {1'b0, hi_q} + w2;

	assign out_free   = !out_valid || !out_stall;
	assign emit_issue = (state_q == ST_EMIT) && (e_q < n_q) && (!pend_q || out_free);
	assign emit_load  = pend_q && out_free;

	// read addresses for the next cycle
	always_comb begin
		rd_en = 1'b0;
		ra    = '0;
		rb    = '0;
		case (state_q)
			ST_START: begin
				rd_en = 1'b1;
				ra    = '0;
				rb    = w_q;
			end
			ST_MERGE: begin
				rd_en = 1'b1;
				if (run_end) begin
					ra = hi_q;
					rb = nmid_q;
				end else begin
					ra = a_inc;
					rb = b_inc;
				end
			end
			ST_EMIT: begin
				rd_en = emit_issue;
				ra    = e_q;
				rb    = e_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	assign we0 = store || ((state_q == ST_MERGE) && sel_q);
	assign we1 = (state_q == ST_MERGE) && !sel_q;
	assign wa0 = (state_q == ST_MERGE) ? k_q : count_q;
	assign wd0 = (state_q == ST_MERGE) ? wdata : value;

	always_ff @(posedge clk) begin
		if (we0) begin
			bank0_q[wa0[IDX_W-1:0]] <= wd0;
		end
		if (rd_en) begin
			rd0a_q <= bank0_q[ra[IDX_W-1:0]];
			rd0b_q <= bank0_q[rb[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (we1) begin
			bank1_q[k_q[IDX_W-1:0]] <= wdata;
		end
		if (rd_en) begin
			rd1a_q <= bank1_q[ra[IDX_W-1:0]];
			rd1b_q <= bank1_q[rb[IDX_W-1:0]];
		end
	end

	// boundaries of the following run, registered from hi_q; runs before the last
	// are at least two words long, so they are settled before they are used
	always_ff @(posedge clk) begin
		nmid_q <= (hw_sum < {1'b0, n_q}) ? hw_sum[CNT_W-1:0] : n_q;
		nhi_q  <= (hw2_sum < {1'b0, n_q}) ? hw2_sum[CNT_W-1:0] : n_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			n_q         <= '0;
			w_q         <= '0;
			a_q         <= '0;
			b_q         <= '0;
			mid_q       <= '0;
			hi_q        <= '0;
			k_q         <= '0;
			sel_q       <= 1'b0;
			e_q         <= '0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						count_q <= count_nxt;
						if (!store) begin
							dropped_q <= 1'b1;
						end
						if (last) begin
							n_q   <= count_nxt;
							w_q   <= CNT_W'(1);
							sel_q <= 1'b0;
							e_q   <= '0;
							if (count_nxt >= CNT_W'(2)) begin
								state_q <= ST_START;
							end else begin
								state_q <= ST_EMIT;
							end
						end
					end
				end
				ST_START: begin
					a_q     <= '0;
					b_q     <= w_q;
					mid_q   <= w_q;
					hi_q    <= hi_start[CNT_W-1:0];
					k_q     <= '0;
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					k_q <= k_q + CNT_W'(1);
					if (run_end) begin
						a_q   <= hi_q;
						b_q   <= nmid_q;
						mid_q <= nmid_q;
						hi_q  <= nhi_q;
					end else begin
						a_q <= a_inc;
						b_q <= b_inc;
					end
					if (pass_end) begin
						sel_q <= !sel_q;
						if (sort_done) begin
							e_q     <= '0;
							state_q <= ST_EMIT;
						end else begin
							w_q     <= w2[CNT_W-1:0];
							state_q <= ST_START;
						end
					end
				end
				ST_EMIT: begin
					if (emit_issue) begin
						e_q         <= e_q + CNT_W'(1);
						pend_q      <= 1'b1;
						pend_last_q <= (e_q + CNT_W'(1)) == n_q;
					end else if (out_free) begin
						pend_q <= 1'b0;
					end
					if (emit_load && pend_last_q) begin
						count_q   <= '0;
						dropped_q <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			value_res <= sel_q ? rd1a_q : rd0a_q;
			last_res  <= pend_last_q;
			overflow  <= dropped_q;
		end
	end

`ifndef SYNTHESIS
	a_merge_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> (a_q <= mid_q && b_q <= hi_q && k_q < n_q))
		else $error("merge pointers out of run bounds");

	a_pass_swap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE && pass_end) |=> (sel_q != $past(sel_q)))
		else $error("banks not swapped at end of pass");

	a_pend_emit: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == ST_EMIT))
		else $error("read data pending outside emission");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (count_q <= CNT_W'(CAPACITY)))
		else $error("fill count beyond capacity");
`endif

endmodule

`default_nettype wire

@@ verif/merge_sorter_core_tb.sv @@
`timescale 1ns / 1ps

module merge_sorter_core_tb;
	import ms_pkg::*;

	localparam int CAP        = CAPACITY_DEF;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE     = 4;
	localparam int HOLD_LEN   = 300;
	localparam int HOLD_AT    = 40;
	localparam int TAIL_WAIT  = 50;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic                     tail;
		logic [1:0]               gap;
		logic                     drain;
	} word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic                     tail;
		logic                     ovf;
	} sorted_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     in_stall;
	logic signed [DATA_W-1:0] value     = '0;
	logic                     last      = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] value_res;
	logic                     last_res;
	logic                     overflow;

	word_t   pending_q[$];
	sorted_t sorted_q[$];

	// shadow of the block being collected
	logic signed [DATA_W-1:0] blk_buf [CAP];
	int                       blk_cnt  = 0;
	logic                     blk_drop = 1'b0;

	int errors      = 0;
	int idle_cycles = 0;

	merge_sorter_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value_res (value_res),
		.last_res  (last_res),
		.overflow  (overflow)
	);

	always #4 clk = ~clk;

	// store one word, and on the closing word sort the block and queue its results
	task automatic take_word(input logic signed [DATA_W-1:0] v, input logic l);
		logic signed [DATA_W-1:0] key;
		int j;
		if (blk_cnt < CAP) begin
			blk_buf[blk_cnt] = v;
			blk_cnt++;
		end else begin
			blk_drop = 1'b1;
		end
		if (l) begin
			for (int i = 1; i < blk_cnt; i++) begin
				key = blk_buf[i];
				j = i - 1;
				while (j >= 0 && blk_buf[j] > key) begin
					blk_buf[j + 1] = blk_buf[j];
					j--;
				end
				blk_buf[j + 1] = key;
			end
			for (int k = 0; k < blk_cnt; k++)
				sorted_q.push_back('{blk_buf[k], k == blk_cnt - 1, blk_drop});
			blk_cnt = 0;
			blk_drop = 1'b0;
		end
	endtask

	task automatic queue_word(input logic signed [DATA_W-1:0] v, input logic l,
			input bit calm, input bit drain);
		word_t w;
		w.data  = v;
		w.tail  = l;
		w.gap   = calm ? 2'd0 : 2'($urandom_range(0, 3));
		w.drain = drain;
		pending_q.push_back(w);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value(input int unsigned mode);
		case (mode)
			2: pick_value = $urandom_range(0, 6) - 3;
			3: begin
				case ($urandom_range(0, 5))
					0: pick_value = 32'sh8000_0000;
					1: pick_value = 32'sh8000_0001;
					2: pick_value = -1;
					3: pick_value = 0;
					4: pick_value = 32'sh7fff_fffe;
					default: pick_value = 32'sh7fff_ffff;
				endcase
			end
			default: pick_value = $urandom;
		endcase
	endfunction

	// driver
	int    gap_left = 0;
	bit    armed    = 1'b0;
	word_t nxt;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			value <= '0;
			last <= 1'b0;
			gap_left = 0;
			armed = 1'b0;
		end else begin
			if (in_valid && !in_stall)
				take_word(value, last);
			if (in_valid && in_stall) begin
				// word held until the block takes it
			end else if (pending_q.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				if (!armed) begin
					gap_left = pending_q[0].gap;
					armed = 1'b1;
				end
				if (pending_q[0].drain && sorted_q.size() != 0) begin
					in_valid <= 1'b0;
					gap_left = SETTLE;
				end else if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else begin
					nxt = pending_q.pop_front();
					in_valid <= 1'b1;
					value <= nxt.data;
					last <= nxt.tail;
					armed = 1'b0;
				end
			end
		end
	end

	// monitor
	sorted_t exp_w;
	int      stall_left = 0;
	int      hold_left  = 0;
	int      res_cnt    = 0;
	bit      rx_calm    = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (hold_left > 0)
				hold_left--;
			if (out_valid && !out_stall) begin
				if (sorted_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected word value_res=%0d last_res=%0b overflow=%0b",
							value_res, last_res, overflow);
				end else begin
					exp_w = sorted_q.pop_front();
					if (value_res !== exp_w.data || last_res !== exp_w.tail ||
							overflow !== exp_w.ovf) begin
						errors++;
						if (errors <= 10)
							$display("mismatch word %0d: exp %0d/%0b/%0b got %0d/%0b/%0b",
								res_cnt, $signed(exp_w.data), exp_w.tail, exp_w.ovf,
								value_res, last_res, overflow);
					end
				end
				res_cnt++;
				if (res_cnt % 32 == 0)
					rx_calm = $urandom_range(0, 2) == 0;
				// long hold-off so the block backs up into its input
				if (res_cnt == HOLD_AT)
					hold_left = HOLD_LEN;
				stall_left = rx_calm ? 0 : $urandom_range(0, 3);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_stall <= (hold_left > 0) || (stall_left > 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int          dir_vals[$];
		bit [20:0]   dir_last;
		int unsigned n_words;
		int unsigned blk;
		int unsigned size;
		int unsigned mode;
		int unsigned r;
		bit          calm;

		// single words, pairs, ties, extremes, descending run
		dir_vals = '{32'sh7fff_ffff, 32'sh8000_0000, 5, -5, 7, 7,
			32'sh7fff_ffff, 32'sh8000_0000, 0, -1, 1, 32'sh8000_0000, 32'sh7fff_ffff,
			3, 2, 1, 0, -1, -2, -3, -4};
		dir_last = 21'h10102B;
		for (int i = 0; i < 21; i++)
			queue_word(dir_vals[i], dir_last[i], 1'b0, 1'b0);

		n_words = 21;
		blk = 0;
		while (n_words < 300 || blk < 12) begin
			if (blk == 2) begin
				size = CAP;
			end else if (blk == 5) begin
				// closing word itself is dropped
				size = CAP + 1;
			end else if (blk == 9) begin
				size = $urandom_range(CAP + 2, CAP + 8);
			end else begin
				r = $urandom_range(0, 9);
				if (r < 7)
					size = $urandom_range(1, 12);
				else if (r < 9)
					size = $urandom_range(13, 40);
				else
					size = $urandom_range(41, CAP);
			end
			calm = $urandom_range(0, 3) == 0;
			mode = $urandom_range(0, 3);
			for (int i = 0; i < size; i++)
				queue_word(pick_value(mode), i == size - 1, calm,
					i == 0 && (blk == 0 || blk % 8 == 7));
			n_words += size;
			blk++;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || in_valid)
			@(posedge clk);
		while (sorted_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		if (sorted_q.size() != 0) begin
			errors++;
			$display("%0d sorted words never arrived", sorted_q.size());
		end
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
